[rtl/assert_macros.svh]
// Assertion macros shared by the slot table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define EST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define EST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/est_pkg.sv]
// Shared types and constants of the expiring slot table.
package est_pkg;

  localparam int CMD_W     = 1;
  localparam int TIME_IN_W = 32;
  localparam int CAP_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int ID_W      = 4;

  // at most this many expiries are reported by one tick
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXPIRED = 2'd2
  } status_t;

  // one result word
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   slot_id;
    logic              last;
  } res_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[rtl/est_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface est_in_if import est_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [TIME_IN_W-1:0] now;
  logic [TIME_IN_W-1:0] lifetime;

  modport source (output valid, command, now, lifetime, input ready);
  modport sink   (input valid, command, now, lifetime, output ready);
endinterface

interface est_out_if import est_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     slot_id;
  logic                last;

  modport source (output valid, status, slot_id, last, input ready);
  modport sink   (input valid, status, slot_id, last, output ready);
endinterface

[rtl/est_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module est_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/est_queue.sv]
// Two-entry command queue between the front and the execution engine.
`include "assert_macros.svh"

module est_queue import est_pkg::*; #(
  parameter int WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign rdata      = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    case ({wr, rd})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) begin
        mem_r[wr_ptr_r] <= wdata;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `EST_ASSERT(a_q_no_overflow, wr |-> (!stat.full || rd), "queue written while full")

endmodule

[rtl/est_front.sv]
// Front: takes command words, trims time stamps and precomputes the end time.
module est_front import est_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  est_in_if.sink                 in_ch,
  input  q_stat_t                q_stat,
  output logic                   q_wr,
  output logic [2*TIME_BITS+1:0] q_wdata
);

  logic [TIME_BITS-1:0] now_q, life_q;
  logic [TIME_BITS:0]   end_sum;

  assign now_q   = TIME_BITS'(in_ch.now);
  assign life_q  = TIME_BITS'(in_ch.lifetime);

  // end time with carry; a carry means the slot never expires
  assign end_sum = {1'b0, now_q} + {1'b0, life_q};

  assign in_ch.ready = !q_stat.full;
  assign q_wr        = in_ch.valid && !q_stat.full;
  assign q_wdata     = {in_ch.command, end_sum[TIME_BITS], end_sum[TIME_BITS-1:0], now_q};

endmodule

[rtl/est_engine.sv]
// Back end: allocates slots on put and walks the live list on tick.
`include "assert_macros.svh"

module est_engine import est_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CAP_W-1:0]       capacity,
  input  q_stat_t                q_stat,
  input  logic [2*TIME_BITS+1:0] q_rdata,
  output logic                   q_pop,
  est_out_if.source              out_ch
);

  localparam int SID = $clog2(SLOTS);
  localparam int LW  = $clog2(SLOTS + 1);
  localparam int CMW = (LW > CAP_W) ? LW : CAP_W;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_PUT, S_WALK, S_FLUSH} state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   newest_r, newest_nxt;
  logic [LW-1:0]   free_top_r, free_top_nxt;
  logic [LW-1:0]   bump_r, bump_nxt;
  logic [LW-1:0]   cur_r, cur_nxt;
  logic [LW-1:0]   prev_r, prev_nxt;
  logic [LW-1:0]   guard_r, guard_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [SID-1:0]  pend_id_r, pend_id_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_word_r, out_word;
  logic            out_push, out_free;

  // queue head fields
  logic                 h_cmd, h_never;
  logic [TIME_BITS-1:0] h_end, h_now;

  // RAM ports
  logic [SID-1:0]       rd_addr;
  logic                 link_we, time_we, free_we;
  logic [SID-1:0]       link_waddr, time_waddr, free_waddr;
  logic [LW-1:0]        link_wdata, free_wdata, link_rdata, free_rdata;
  logic [TIME_BITS:0]   time_wdata, time_rdata;

  logic                 expired, stall, cap_ok, alloc;
  logic [LW-1:0]        slot;

  assign h_cmd   = q_rdata[2*TIME_BITS+1];
  assign h_never = q_rdata[2*TIME_BITS];
  assign h_end   = q_rdata[2*TIME_BITS-1:TIME_BITS];
  assign h_now   = q_rdata[TIME_BITS-1:0];

  // per-slot end time with never-expire flag
  est_ram #(.WIDTH(TIME_BITS + 1), .DEPTH(SLOTS)) u_time_ram (
    .clk(clk), .we(time_we), .waddr(time_waddr), .wdata(time_wdata),
    .raddr(rd_addr), .rdata(time_rdata)
  );

  // older neighbor in the live list
  est_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata(link_rdata)
  );

  // free stack links
  est_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_top_r[SID-1:0]), .rdata(free_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign expired  = !time_rdata[TIME_BITS] && (h_now >= time_rdata[TIME_BITS-1:0]);
  assign stall    = expired && pend_v_r && !out_free;
  assign cap_ok   = (CMW'(bump_r) < CMW'(capacity)) && (CMW'(bump_r) < CMW'(SLOTS));

  // command sequencing
  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    free_top_nxt  = free_top_r;
    bump_nxt      = bump_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    guard_nxt     = guard_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    rd_addr       = cur_r[SID-1:0];
    link_we       = 1'b0;
    link_waddr    = prev_r[SID-1:0];
    link_wdata    = link_rdata;
    time_we       = 1'b0;
    time_waddr    = bump_r[SID-1:0];
    time_wdata    = {h_never, h_end};
    free_we       = 1'b0;
    free_waddr    = cur_r[SID-1:0];
    free_wdata    = free_top_r;
    q_pop         = 1'b0;
    out_push      = 1'b0;
    out_word      = '{status: ST_OK, slot_id: '0, last: 1'b1};
    alloc         = 1'b0;
    slot          = bump_r;

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          if (h_cmd == CMD_PUT) begin
            state_nxt = S_PUT;
          end else if (newest_r < NIL) begin
            rd_addr   = newest_r[SID-1:0];
            cur_nxt   = newest_r;
            prev_nxt  = NIL;
            guard_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = S_WALK;
          end else begin
            q_pop = 1'b1;
          end
        end
      end

      S_PUT: begin
        if (out_free) begin
          q_pop     = 1'b1;
          out_push  = 1'b1;
          state_nxt = S_IDLE;
          if (free_top_r < NIL) begin
            alloc        = 1'b1;
            slot         = free_top_r;
            free_top_nxt = free_rdata;
          end else if (cap_ok) begin
            alloc    = 1'b1;
            slot     = bump_r;
            bump_nxt = bump_r + LW'(1);
          end
          if (alloc) begin
            time_we    = 1'b1;
            time_waddr = slot[SID-1:0];
            link_we    = 1'b1;
            link_waddr = slot[SID-1:0];
            link_wdata = newest_r;
            newest_nxt = slot;
            out_word   = '{status: ST_OK, slot_id: ID_W'(slot), last: 1'b1};
          end else begin
            out_word   = '{status: ST_FULL, slot_id: '0, last: 1'b1};
          end
        end
      end

      S_WALK: begin
        if (!stall) begin
          guard_nxt = guard_r + LW'(1);
          cur_nxt   = link_rdata;
          if (expired) begin
            // unlink: the newer neighbor is the last kept slot of this walk
            if (prev_r < NIL) begin
              link_we = 1'b1;
            end else begin
              newest_nxt = link_rdata;
            end
            // top of the bump area shrinks it, anything else is stacked
            if (bump_r != '0 && cur_r == bump_r - LW'(1)) begin
              bump_nxt = bump_r - LW'(1);
            end else begin
              free_we      = 1'b1;
              free_top_nxt = cur_r;
            end
            if (pend_v_r) begin
              out_push = 1'b1;
              out_word = '{status: ST_EXPIRED, slot_id: ID_W'(pend_id_r), last: 1'b0};
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = cur_r[SID-1:0];
            cnt_nxt     = cnt_r + CNT_W'(1);
          end else begin
            prev_nxt = cur_r;
          end
          if (link_rdata < NIL && guard_nxt < NIL && cnt_nxt < CNT_W'(MAX_RESULTS)) begin
            rd_addr = link_rdata[SID-1:0];
          end else if (pend_v_nxt) begin
            state_nxt = S_FLUSH;
          end else begin
            q_pop     = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_push   = 1'b1;
          out_word   = '{status: ST_EXPIRED, slot_id: ID_W'(pend_id_r), last: 1'b1};
          pend_v_nxt = 1'b0;
          q_pop      = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_push ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // state and registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= NIL;
      free_top_r  <= NIL;
      bump_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      free_top_r  <= free_top_nxt;
      bump_r      <= bump_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      guard_r     <= guard_nxt;
      cnt_r       <= cnt_nxt;
      pend_id_r   <= pend_id_nxt;
      if (out_push) begin
        out_word_r <= out_word;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_word_r.status;
  assign out_ch.slot_id = out_word_r.slot_id;
  assign out_ch.last    = out_word_r.last;

  `EST_ASSERT(a_push_when_free, out_push |-> (!out_valid_r || out_ch.ready), "result overwritten")
  `EST_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from empty queue")
  `EST_ASSERT(a_stall_holds, (state_r == S_WALK && stall) |=> (cur_r == $past(cur_r)), "walk moved while stalled")
  `EST_ASSERT_ALWAYS(a_bump_range, !rst_n || bump_r <= NIL, "bump count past table size")

endmodule

[rtl/expiring_slot_table.sv]
// Expiring slot table top level: capacity register, front, queue and engine.
//
// Commands enter a two-deep queue; results leave through a registered output,
// so a new command is taken while a result waits. A put passes through the
// idle state, where the free stack is read, then allocates in the put state
// once the output is free. A tick starts in the idle state, then walks the
// live slots newest to oldest through the link RAM, one older-neighbor read
// per cycle while the output does not stall it, and then sends its final
// expiry. A tick with no live slot or nothing expired sends nothing. At most
// 16 expiries are reported per tick; the rest are freed by later ticks. The
// slot RAMs need no clearing after reset. The user writes the capacity register
// (reset 16) only while the block is idle; the block itself does not enforce it.
module expiring_slot_table import est_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  est_in_if.sink           in_ch,
  est_out_if.source        out_ch
);

  localparam int QW = 2 * TIME_BITS + 2;

  logic [CAP_W-1:0] cap_r;
  logic             q_wr, q_pop;
  logic [QW-1:0]    q_wdata, q_rdata;
  q_stat_t          q_stat;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  est_front #(.TIME_BITS(TIME_BITS)) u_front (
    .in_ch(in_ch), .q_stat(q_stat), .q_wr(q_wr), .q_wdata(q_wdata)
  );

  est_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr(q_wr), .wdata(q_wdata),
    .rd(q_pop), .rdata(q_rdata), .stat(q_stat)
  );

  est_engine #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .capacity(cap_r), .q_stat(q_stat),
    .q_rdata(q_rdata), .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule

[tb/est_checker.sv]
// Checker for the expiring slot table: tracks the slot state, predicts result words, compares.
`timescale 1ns / 100ps
module est_checker import est_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  est_in_if                in_mon,
  est_out_if               out_mon,
  output int               fail_count,
  output int               words_due,
  output int               puts_seen,
  output int               refused_seen,
  output int               ticks_seen,
  output int               expired_seen
);

  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOTS);

  // shadow copy of the slot table
  logic [TIME_IN_W-1:0] slot_start [SLOTS];
  logic [TIME_IN_W-1:0] slot_life  [SLOTS];
  logic [LINK_W-1:0]    link_older [SLOTS];
  logic [LINK_W-1:0]    link_newer [SLOTS];
  logic [LINK_W-1:0]    link_free  [SLOTS];
  logic [LINK_W-1:0]    head_live;
  logic [LINK_W-1:0]    head_free;
  logic [LINK_W-1:0]    bump_used;
  logic [CAP_W-1:0]     cap_reg;

  // result words still owed by the block, oldest first
  res_t owed_words[$];
  int   fails, n_put, n_full, n_tick, n_exp;

  initial begin
    fails  = 0;
    n_put  = 0;
    n_full = 0;
    n_tick = 0;
    n_exp  = 0;
  end

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_start[i] = '0;
      slot_life[i]  = '0;
      link_older[i] = NO_SLOT;
      link_newer[i] = NO_SLOT;
      link_free[i]  = NO_SLOT;
    end
    head_live = NO_SLOT;
    head_free = NO_SLOT;
    bump_used = '0;
    cap_reg   = CAP_RESET;
    owed_words.delete();
  endtask

  // an end time that carries out of the time range never expires
  function automatic bit slot_expired(logic [LINK_W-1:0] s, logic [TIME_IN_W-1:0] t);
    logic [TIME_IN_W:0] end_sum;
    end_sum = {1'b0, slot_start[s]} + {1'b0, slot_life[s]};
    return !end_sum[TIME_IN_W] && (t >= end_sum[TIME_IN_W-1:0]);
  endfunction

  // unlink from the live list; top of the bump area shrinks it, else push on the free stack
  task automatic release_slot(logic [LINK_W-1:0] s);
    logic [LINK_W-1:0] older, newer;
    older = link_older[s];
    newer = link_newer[s];
    if (newer < SLOTS) link_older[newer] = older;
    else head_live = older;
    if (older < SLOTS) link_newer[older] = newer;
    if (bump_used > 0 && s == bump_used - 1) begin
      bump_used = bump_used - 1'b1;
    end else begin
      link_free[s] = head_free;
      head_free    = s;
    end
  endtask

  task automatic predict_put(logic [TIME_IN_W-1:0] t, logic [TIME_IN_W-1:0] life);
    logic [CAP_W-1:0]  lim;
    logic [LINK_W-1:0] s;
    res_t              w;
    lim = (cap_reg > SLOTS) ? CAP_W'(SLOTS) : cap_reg;
    n_put++;
    // free stack first, then the bump area
    if (head_free < SLOTS) begin
      s         = head_free;
      head_free = link_free[s];
    end else if (bump_used < lim) begin
      s         = bump_used;
      bump_used = bump_used + 1'b1;
    end else begin
      w.status  = ST_FULL;
      w.slot_id = '0;
      w.last    = 1'b1;
      owed_words.push_back(w);
      n_full++;
      return;
    end
    slot_start[s] = t;
    slot_life[s]  = life;
    link_newer[s] = NO_SLOT;
    link_older[s] = head_live;
    if (head_live < SLOTS) link_newer[head_live] = s;
    head_live = s;
    w.status  = ST_OK;
    w.slot_id = s[ID_W-1:0];
    w.last    = 1'b1;
    owed_words.push_back(w);
  endtask

  // walk newest to oldest; the previous expiry is held back so the final one gets last
  task automatic predict_tick(logic [TIME_IN_W-1:0] t);
    logic [LINK_W-1:0] cur, nxt;
    int                visited, found;
    res_t              held;
    cur     = head_live;
    visited = 0;
    found   = 0;
    held    = '0;
    n_tick++;
    while (cur < SLOTS && visited < SLOTS && found < MAX_RESULTS) begin
      nxt = link_older[cur];
      visited++;
      if (slot_expired(cur, t)) begin
        release_slot(cur);
        if (found > 0) owed_words.push_back(held);
        held.status  = ST_EXPIRED;
        held.slot_id = cur[ID_W-1:0];
        held.last    = 1'b0;
        found++;
      end
      cur = nxt;
    end
    if (found > 0) begin
      held.last = 1'b1;
      owed_words.push_back(held);
      n_exp += found;
    end
  endtask

  task automatic check_word();
    res_t want;
    if (owed_words.size() == 0) begin
      fails++;
      $display("%0t: result word with none expected: status=%0d slot=%0d last=%0b",
               $time, out_mon.status, out_mon.slot_id, out_mon.last);
      return;
    end
    want = owed_words.pop_front();
    if (out_mon.status !== want.status || out_mon.slot_id !== want.slot_id ||
        out_mon.last !== want.last) begin
      fails++;
      $display("%0t: mismatch: expected status=%0d slot=%0d last=%0b, got status=%0d slot=%0d last=%0b",
               $time, want.status, want.slot_id, want.last,
               out_mon.status, out_mon.slot_id, out_mon.last);
    end
  endtask

  // inputs first, so a same-edge result can never overtake its own prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_PUT) predict_put(in_mon.now, in_mon.lifetime);
        else predict_tick(in_mon.now);
      end
      if (out_mon.valid && out_mon.ready) check_word();
    end
    fail_count   <= fails;
    words_due    <= owed_words.size();
    puts_seen    <= n_put;
    refused_seen <= n_full;
    ticks_seen   <= n_tick;
    expired_seen <= n_exp;
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the expiring slot table: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps
module tb_top;
  import est_pkg::*;

  localparam int SLOTS         = 16;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam logic [TIME_IN_W-1:0] T_MAX = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  est_in_if  in_ch();
  est_out_if out_ch();

  int fail_count, words_due;
  int puts_seen, refused_seen, ticks_seen, expired_seen;

  // idling control shared by sender and receiver
  bit quiet       = 1'b0;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  logic [TIME_IN_W-1:0] time_base;

  expiring_slot_table #(
    .SLOTS    (SLOTS),
    .TIME_BITS(32)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  est_checker #(
    .SLOTS(SLOTS)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .words_due   (words_due),
    .puts_seen   (puts_seen),
    .refused_seen(refused_seen),
    .ticks_seen  (ticks_seen),
    .expired_seen(expired_seen)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d result words still owed", $time, words_due);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99) >= 23);
      end
    end
  end

  // offer one word, with random gaps ahead of it, and wait for acceptance
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [TIME_IN_W-1:0] t,
                           logic [TIME_IN_W-1:0] life);
    while (!quiet && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.now      <= t;
    in_ch.lifetime <= life;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering, wait for every owed word, then let queued silent tick walks finish
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly puts and ticks around a slowly moving clock, with some wild times
  task automatic run_phase(int count, bit mid_pause);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) drain_results();
      pick      = $urandom_range(99);
      time_base = time_base + $urandom_range(0, 6);
      if (pick < 44) send_word(CMD_PUT, time_base, $urandom_range(0, 100));
      else if (pick < 47) send_word(CMD_PUT, time_base, $urandom());
      else if (pick < 50) send_word(CMD_PUT, $urandom(), $urandom_range(0, 100));
      else if (pick < 84) send_word(CMD_TICK, time_base, $urandom());
      else if (pick < 91) send_word(CMD_TICK, time_base - $urandom_range(0, 30), $urandom());
      else if (pick < 96) send_word(CMD_TICK, $urandom(), $urandom());
      else send_word(CMD_TICK, T_MAX, $urandom());
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_PUT;
    in_ch.now      = '0;
    in_ch.lifetime = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    time_base      = $urandom_range(0, 1000);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_capacity(CAP_W'(16));

    // directed: tick on an empty table
    send_word(CMD_TICK, '0, T_MAX);
    // fill every slot with zero lifetime, then one put too many
    for (int i = 0; i < SLOTS; i++) send_word(CMD_PUT, 32'd7, '0);
    send_word(CMD_PUT, 32'd7, '0);
    // a single tick frees all sixteen, newest first
    send_word(CMD_TICK, 32'd7, '0);
    // end time carries out of range: this slot never expires
    send_word(CMD_PUT, T_MAX, 32'd1);
    // all-ones lifetime from zero ends at the top of the range
    send_word(CMD_PUT, '0, T_MAX);
    send_word(CMD_PUT, 32'd3, 32'd1);
    send_word(CMD_PUT, 32'd4, 32'd50);
    // middle slot expires and goes on the free stack
    send_word(CMD_TICK, 32'd4, '0);
    send_word(CMD_PUT, 32'd5, '0);
    // expire everything that can expire
    send_word(CMD_TICK, T_MAX, T_MAX);

    // random phases over several capacities; bump area already at the first one
    write_capacity(CAP_W'(3));
    run_phase(60, 1'b0);

    // long receiver hold-off while the sender keeps pushing, then a full drain mid-phase
    write_capacity(CAP_W'(16));
    hold_asked = hold_asked + 1;
    run_phase(60, 1'b1);

    write_capacity(CAP_W'(5));
    run_phase(60, 1'b0);
    write_capacity(CAP_W'(1));
    run_phase(60, 1'b0);
    write_capacity(CAP_W'(0));
    run_phase(50, 1'b0);
    write_capacity(CAP_W'(31));
    run_phase(60, 1'b0);
    write_capacity(CAP_W'(9));
    run_phase(50, 1'b0);

    // no idling on either side
    write_capacity(CAP_W'(16));
    quiet = 1'b1;
    run_phase(80, 1'b0);

    drain_results();
    $display("covered %0d puts (%0d refused) and %0d ticks freeing %0d slots,",
             puts_seen, refused_seen, ticks_seen, expired_seen);
    $display("capacities 0, 1, 3, 5, 9, 16 and 31, with stalls and a long hold-off");
    if (fail_count == 0 && words_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
